// ----- rtl/utv_pkg.sv -----
// ----------------------------------------------------------------------------
// utv_pkg
// Shared types and constants for the UTF-8 text validator: fault codes,
// per-text decode state and the verdict record.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package utv_pkg;

  // Fault codes; only the first fault of a text is reported on the output
  typedef enum logic [2:0] {
    FAULT_NONE      = 3'd0,
    FAULT_TOO_LONG  = 3'd1,
    FAULT_NUL       = 3'd2,
    FAULT_BAD_LEAD  = 3'd3,
    FAULT_BAD_TAIL  = 3'd4,
    FAULT_TRUNCATED = 3'd5,
    FAULT_OVERLONG  = 3'd6,
    FAULT_RANGE     = 3'd7
  } fault_t;

  localparam int unsigned CP_W    = 21;
  localparam int unsigned COUNT_W = 32;

  localparam logic [COUNT_W-1:0] MAX_TEXT_BYTES_RST = 32'd4096;
  localparam logic [COUNT_W-1:0] COUNT_SAT          = '1;

  // Lead byte ranges
  localparam logic [7:0] LEAD2_LO = 8'hc2;
  localparam logic [7:0] LEAD2_HI = 8'hdf;
  localparam logic [7:0] LEAD3_LO = 8'he0;
  localparam logic [7:0] LEAD3_HI = 8'hef;
  localparam logic [7:0] LEAD4_LO = 8'hf0;
  localparam logic [7:0] LEAD4_HI = 8'hf4;

  // Code point limits
  localparam logic [CP_W-1:0] CP_MIN2    = 21'h000080;
  localparam logic [CP_W-1:0] CP_MIN3    = 21'h000800;
  localparam logic [CP_W-1:0] CP_MIN4    = 21'h010000;
  localparam logic [CP_W-1:0] CP_MAX     = 21'h10ffff;
  localparam logic [CP_W-1:0] CP_SURR_LO = 21'h00d800;
  localparam logic [CP_W-1:0] CP_SURR_HI = 21'h00dfff;

  // Decode state of the text in progress
  typedef struct packed {
    logic [1:0]         tails_left;
    logic [1:0]         sequence_length;
    logic [CP_W-1:0]    code_point;
    logic [COUNT_W-1:0] bytes_seen;
    fault_t             first_fault;
  } text_state_t;

  // Verdict for one text
  typedef struct packed {
    logic [COUNT_W-1:0] text_length;
    fault_t             error_code;
    logic               text_valid;
  } verdict_t;

endpackage

// ----- rtl/utv_step.sv -----
// ----------------------------------------------------------------------------
// utv_step
// Combinational update for one item: counts the byte, checks the length
// limit, decodes strict UTF-8 and forms the verdict at end of text.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module utv_step
  import utv_pkg::*;
(
  input  text_state_t        st,
  input  logic [7:0]         data_byte,
  input  logic               end_of_text,
  input  logic               empty_text,
  input  logic [COUNT_W-1:0] max_text_bytes,
  output text_state_t        st_next,
  output logic               verdict_ready,
  output verdict_t           verdict
);

  logic            too_long;
  logic [CP_W-1:0] cp_shift;
  logic [CP_W-1:0] cp_least;
  fault_t          dec_fault;
  logic [1:0]      dec_tails;
  logic [1:0]      dec_seq;
  logic [CP_W-1:0] dec_cp;
  text_state_t     upd;
  fault_t          end_fault;

  // Count before this byte already at the limit (covers saturation too)
  assign too_long = (st.bytes_seen >= max_text_bytes);
  assign cp_shift = {st.code_point[CP_W-7:0], data_byte[5:0]};

  // Smallest legal value for the sequence being finished
  always_comb begin
    case (st.sequence_length)
      2'd1:    cp_least = CP_MIN2;
      2'd2:    cp_least = CP_MIN3;
      default: cp_least = CP_MIN4;
    endcase
  end

  // Byte decode
  always_comb begin
    dec_fault = FAULT_NONE;
    dec_tails = st.tails_left;
    dec_seq   = st.sequence_length;
    dec_cp    = st.code_point;
    if (st.tails_left != 2'd0) begin
      if (data_byte[7:6] != 2'b10) begin
        dec_fault = FAULT_BAD_TAIL;
      end else begin
        dec_cp    = cp_shift;
        dec_tails = st.tails_left - 2'd1;
        if (dec_tails == 2'd0) begin
          if (cp_shift < cp_least) begin
            dec_fault = FAULT_OVERLONG;
          end else if (cp_shift > CP_MAX ||
                       (cp_shift >= CP_SURR_LO && cp_shift <= CP_SURR_HI)) begin
            dec_fault = FAULT_RANGE;
          end
        end
      end
    end else if (data_byte == 8'h00) begin
      dec_fault = FAULT_NUL;
    end else if (!data_byte[7]) begin
      dec_fault = FAULT_NONE;
    end else if (data_byte >= LEAD2_LO && data_byte <= LEAD2_HI) begin
      dec_seq   = 2'd1;
      dec_tails = 2'd1;
      dec_cp    = {{(CP_W-5){1'b0}}, data_byte[4:0]};
    end else if (data_byte >= LEAD3_LO && data_byte <= LEAD3_HI) begin
      dec_seq   = 2'd2;
      dec_tails = 2'd2;
      dec_cp    = {{(CP_W-4){1'b0}}, data_byte[3:0]};
    end else if (data_byte >= LEAD4_LO && data_byte <= LEAD4_HI) begin
      dec_seq   = 2'd3;
      dec_tails = 2'd3;
      dec_cp    = {{(CP_W-3){1'b0}}, data_byte[2:0]};
    end else begin
      dec_fault = FAULT_BAD_LEAD;
    end
  end

  // State update; after the first fault bytes are only counted
  always_comb begin
    upd = st;
    if (!empty_text) begin
      if (st.bytes_seen != COUNT_SAT) begin
        upd.bytes_seen = st.bytes_seen + 32'd1;
      end
      if (st.first_fault == FAULT_NONE) begin
        if (too_long) begin
          upd.first_fault = FAULT_TOO_LONG;
        end else begin
          upd.first_fault     = dec_fault;
          upd.tails_left      = dec_tails;
          upd.sequence_length = dec_seq;
          upd.code_point      = dec_cp;
        end
      end
    end
  end

  // Verdict at end of text, then clear for the next one
  always_comb begin
    if (upd.first_fault == FAULT_NONE && upd.tails_left != 2'd0) begin
      end_fault = FAULT_TRUNCATED;
    end else begin
      end_fault = upd.first_fault;
    end
    verdict.text_valid  = (end_fault == FAULT_NONE);
    verdict.error_code  = end_fault;
    verdict.text_length = upd.bytes_seen;
    verdict_ready       = end_of_text;
    st_next             = end_of_text ? text_state_t'('0) : upd;
  end

endmodule

// ----- rtl/utf8_text_validator.sv -----
// ----------------------------------------------------------------------------
// utf8_text_validator
// Strict UTF-8 checker with a byte-count limit; one verdict per text.
// ----------------------------------------------------------------------------
// Path: the accepted byte is held in the input register, then decoded
//   into the result register.
// Throughput: one item per cycle while the skid entry is empty; a
//   two-entry result buffer keeps input flowing while one verdict waits.
// Reset: clears all text state and buffers; max_text_bytes returns to 4096.
`timescale 1ns / 1ps

module utf8_text_validator
  import utv_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  // configuration: max_text_bytes
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [31:0]  cfg_data,
  // input bytes
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,   // [7:0] data_byte
  input  logic         s_axis_tlast,   // end_of_text
  input  logic         s_axis_tuser,   // empty_text
  // verdicts
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [39:0]  m_axis_tdata    // [0] text_valid, [3:1] error_code,
                                       // [35:4] text_length, [39:36] zero
);

  logic [COUNT_W-1:0] max_text_bytes;
  text_state_t        st;
  text_state_t        st_next;

  logic               in_valid;
  logic [7:0]         in_byte;
  logic               in_last;
  logic               in_empty;

  logic               verdict_ready;
  verdict_t           verdict;
  logic               step_fire;
  logic               res_push;

  logic               out_valid;
  verdict_t           out_data;
  logic               skid_valid;
  verdict_t           skid_data;
  logic               out_load;

  // Configuration register, always writable
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_text_bytes <= MAX_TEXT_BYTES_RST;
    end else if (cfg_valid) begin
      max_text_bytes <= cfg_data;
    end
  end

  // Input register
  assign step_fire     = in_valid && !skid_valid;
  assign s_axis_tready = !in_valid || !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte  <= s_axis_tdata;
      in_last  <= s_axis_tlast;
      in_empty <= s_axis_tuser;
    end
  end

  // Decode step
  utv_step u_step (
    .st             (st),
    .data_byte      (in_byte),
    .end_of_text    (in_last),
    .empty_text     (in_empty),
    .max_text_bytes (max_text_bytes),
    .st_next        (st_next),
    .verdict_ready  (verdict_ready),
    .verdict        (verdict)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (step_fire) begin
      st <= st_next;
    end
  end

  // Result register with skid entry
  assign res_push = step_fire && verdict_ready;
  assign out_load = !out_valid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_load) begin
      out_valid  <= skid_valid || res_push;
      skid_valid <= 1'b0;
    end else if (res_push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data <= skid_valid ? skid_data : verdict;
    end else if (res_push) begin
      skid_data <= verdict;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {4'b0000, out_data};

endmodule
